@@ sv/cus_pkg.sv @@
package cus_pkg;

  localparam int unsigned RANK_W    = 24;
  localparam int unsigned N_W       = 6;
  localparam int unsigned K_W       = 4;
  localparam int unsigned ELEM_W    = 5;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PC_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 1'd1;

  localparam logic [N_W-1:0] SET_SIZE_RST   = 6'd16;
  localparam logic [K_W-1:0] PICK_COUNT_RST = 4'd8;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_KGTN  = 3'd2,
    ST_DONE  = 3'd3,
    ST_EMPTY = 3'd4
  } cus_status_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_UNR_INIT,
    ACT_WALK,
    ACT_SET_LOADED,
    ACT_CLR_I,
    ACT_EMIT,
    ACT_ADV_INIT,
    ACT_DEC_I,
    ACT_BUMP,
    ACT_FILL,
    ACT_SET_ST,
    ACT_EMIT_ERR
  } cus_act_e;

  typedef enum logic [3:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_INPUT,
    CND_IS_ADV,
    CND_KGTN,
    CND_WALK_BAD,
    CND_WALK_MORE,
    CND_EMIT_LOOP,
    CND_NOT_LOADED,
    CND_I_ZERO,
    CND_CUR_AT_MAX,
    CND_I_EQ_K,
    CND_OUT_BUSY
  } cus_cond_e;

  typedef struct packed {
    cus_act_e        act;
    cus_cond_e       cond;
    logic [PC_W-1:0] target;
    cus_status_e     st;
  } cus_cw_t;

  typedef struct packed {
    logic no_input;
    logic is_adv;
    logic kgtn;
    logic walk_bad;
    logic walk_more;
    logic emit_loop;
    logic not_loaded;
    logic i_zero;
    logic cur_at_max;
    logic i_eq_k;
    logic out_busy;
  } cus_flags_t;

  // microcode addresses
  localparam logic [PC_W-1:0] PC_FETCH     = 5'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH  = 5'd1;
  localparam logic [PC_W-1:0] PC_U_KGTN    = 5'd2;
  localparam logic [PC_W-1:0] PC_U_INIT    = 5'd3;
  localparam logic [PC_W-1:0] PC_U_WALK    = 5'd4;
  localparam logic [PC_W-1:0] PC_U_MORE    = 5'd5;
  localparam logic [PC_W-1:0] PC_U_DONE    = 5'd6;
  localparam logic [PC_W-1:0] PC_EMIT_INIT = 5'd7;
  localparam logic [PC_W-1:0] PC_EMIT      = 5'd8;
  localparam logic [PC_W-1:0] PC_EMIT_RET  = 5'd9;
  localparam logic [PC_W-1:0] PC_A_LOADED  = 5'd10;
  localparam logic [PC_W-1:0] PC_A_KGTN    = 5'd11;
  localparam logic [PC_W-1:0] PC_A_INIT    = 5'd12;
  localparam logic [PC_W-1:0] PC_A_SCAN    = 5'd13;
  localparam logic [PC_W-1:0] PC_A_DEC     = 5'd14;
  localparam logic [PC_W-1:0] PC_A_TEST    = 5'd15;
  localparam logic [PC_W-1:0] PC_A_BUMP    = 5'd16;
  localparam logic [PC_W-1:0] PC_A_CHECK   = 5'd17;
  localparam logic [PC_W-1:0] PC_A_FILL    = 5'd18;
  localparam logic [PC_W-1:0] PC_E_RANGE   = 5'd19;
  localparam logic [PC_W-1:0] PC_E_KGTN    = 5'd20;
  localparam logic [PC_W-1:0] PC_E_DONE    = 5'd21;
  localparam logic [PC_W-1:0] PC_E_EMPTY   = 5'd22;
  localparam logic [PC_W-1:0] PC_E_EMIT    = 5'd23;
  localparam logic [PC_W-1:0] PC_E_RET     = 5'd24;

  function automatic cus_cw_t ucode(logic [PC_W-1:0] pc);
    cus_cw_t cw;
    unique case (pc)
      PC_FETCH:     cw = '{ACT_LATCH,      CND_NO_INPUT,   PC_FETCH,     ST_OK};
      PC_DISPATCH:  cw = '{ACT_NONE,       CND_IS_ADV,     PC_A_LOADED,  ST_OK};
      PC_U_KGTN:    cw = '{ACT_NONE,       CND_KGTN,       PC_E_KGTN,    ST_OK};
      PC_U_INIT:    cw = '{ACT_UNR_INIT,   CND_NEVER,      PC_FETCH,     ST_OK};
      PC_U_WALK:    cw = '{ACT_WALK,       CND_WALK_BAD,   PC_E_RANGE,   ST_OK};
      PC_U_MORE:    cw = '{ACT_NONE,       CND_WALK_MORE,  PC_U_WALK,    ST_OK};
      PC_U_DONE:    cw = '{ACT_SET_LOADED, CND_NEVER,      PC_FETCH,     ST_OK};
      PC_EMIT_INIT: cw = '{ACT_CLR_I,      CND_NEVER,      PC_FETCH,     ST_OK};
      PC_EMIT:      cw = '{ACT_EMIT,       CND_EMIT_LOOP,  PC_EMIT,      ST_OK};
      PC_EMIT_RET:  cw = '{ACT_NONE,       CND_ALWAYS,     PC_FETCH,     ST_OK};
      PC_A_LOADED:  cw = '{ACT_NONE,       CND_NOT_LOADED, PC_E_EMPTY,   ST_OK};
      PC_A_KGTN:    cw = '{ACT_NONE,       CND_KGTN,       PC_E_KGTN,    ST_OK};
      PC_A_INIT:    cw = '{ACT_ADV_INIT,   CND_NEVER,      PC_FETCH,     ST_OK};
      PC_A_SCAN:    cw = '{ACT_NONE,       CND_I_ZERO,     PC_E_DONE,    ST_OK};
      PC_A_DEC:     cw = '{ACT_DEC_I,      CND_NEVER,      PC_FETCH,     ST_OK};
      PC_A_TEST:    cw = '{ACT_NONE,       CND_CUR_AT_MAX, PC_A_SCAN,    ST_OK};
      PC_A_BUMP:    cw = '{ACT_BUMP,       CND_NEVER,      PC_FETCH,     ST_OK};
      PC_A_CHECK:   cw = '{ACT_NONE,       CND_I_EQ_K,     PC_EMIT_INIT, ST_OK};
      PC_A_FILL:    cw = '{ACT_FILL,       CND_ALWAYS,     PC_A_CHECK,   ST_OK};
      PC_E_RANGE:   cw = '{ACT_SET_ST,     CND_ALWAYS,     PC_E_EMIT,    ST_RANGE};
      PC_E_KGTN:    cw = '{ACT_SET_ST,     CND_ALWAYS,     PC_E_EMIT,    ST_KGTN};
      PC_E_DONE:    cw = '{ACT_SET_ST,     CND_ALWAYS,     PC_E_EMIT,    ST_DONE};
      PC_E_EMPTY:   cw = '{ACT_SET_ST,     CND_NEVER,      PC_FETCH,     ST_EMPTY};
      PC_E_EMIT:    cw = '{ACT_EMIT_ERR,   CND_OUT_BUSY,   PC_E_EMIT,    ST_OK};
      PC_E_RET:     cw = '{ACT_NONE,       CND_ALWAYS,     PC_FETCH,     ST_OK};
      default:      cw = '{ACT_NONE,       CND_ALWAYS,     PC_FETCH,     ST_OK};
    endcase
    return cw;
  endfunction

  // pascal triangle, evaluated at elaboration only
  function automatic int unsigned binom(int unsigned a, int unsigned b);
    int unsigned row [9];
    int          r;
    int          j;
    for (j = 0; j < 9; j++) row[j] = (j == 0) ? 1 : 0;
    for (r = 1; r <= int'(a); r++) begin
      for (j = 8; j >= 1; j--) row[j] = row[j] + row[j-1];
    end
    return (b <= 8) ? row[b] : 0;
  endfunction

endpackage

@@ sv/cus_if.sv @@
interface cus_in_if
  import cus_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [RANK_W-1:0] rank_index;

  modport source (output valid, output command, output rank_index, input ready);
  modport sink   (input valid, input command, input rank_index, output ready);
endinterface

interface cus_out_if
  import cus_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic [POS_W-1:0]  position;
  logic              is_last;
  logic [ST_W-1:0]   status;

  modport source (output valid, output element, output position, output is_last,
                  output status, input ready);
  modport sink   (input valid, input element, input position, input is_last,
                  input status, output ready);
endinterface

@@ sv/cus_useq.sv @@
module cus_useq
  import cus_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cus_flags_t flags_i,
  output cus_cw_t    cw_o
);

  logic [PC_W-1:0] pc_q;
  logic [PC_W-1:0] pc_d;
  logic            jump;

  assign cw_o = ucode(pc_q);

  always_comb begin
    unique case (cw_o.cond)
      CND_NEVER:      jump = 1'b0;
      CND_ALWAYS:     jump = 1'b1;
      CND_NO_INPUT:   jump = flags_i.no_input;
      CND_IS_ADV:     jump = flags_i.is_adv;
      CND_KGTN:       jump = flags_i.kgtn;
      CND_WALK_BAD:   jump = flags_i.walk_bad;
      CND_WALK_MORE:  jump = flags_i.walk_more;
      CND_EMIT_LOOP:  jump = flags_i.emit_loop;
      CND_NOT_LOADED: jump = flags_i.not_loaded;
      CND_I_ZERO:     jump = flags_i.i_zero;
      CND_CUR_AT_MAX: jump = flags_i.cur_at_max;
      CND_I_EQ_K:     jump = flags_i.i_eq_k;
      CND_OUT_BUSY:   jump = flags_i.out_busy;
      default:        jump = 1'b1;
    endcase
    pc_d = jump ? cw_o.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ sv/combination_unrank_and_step_top.sv @@
// unrank: walks the candidates one at a time, taking or skipping each, then emits the k elements
// advance: scans back for a position below its maximum, bumps it, refills those after it, emits k
// errors: one result with the status, is_last set, element and position zero; emits wait out stalls
// one command at a time, the next is taken back at the fetch step
// each candidate passes the walk and more steps of the microcode loop, with one binomial lookup
// reset: sequencer at fetch, n = 16, k = 8, nothing loaded, output empty; no clearing pass
module combination_unrank_and_step_top
  import cus_pkg::*;
#(
  parameter int unsigned MAX_SET_SIZE = 32,
  parameter int unsigned MAX_PICKS    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  cus_in_if.sink               in_i,
  cus_out_if.source            out_o
);

  localparam int unsigned I_W    = $clog2(MAX_PICKS + 1);
  localparam int unsigned PIDX_W = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;
  localparam int unsigned AW     = $clog2(MAX_SET_SIZE);
  localparam logic [N_W-1:0] NMax = N_W'(MAX_SET_SIZE);
  localparam logic [K_W-1:0] KMax = K_W'(MAX_PICKS);

  cus_cw_t    cw;
  cus_flags_t flags;

  logic [N_W-1:0]    set_size_q;
  logic [K_W-1:0]    pick_count_q;
  logic              loaded_q;
  logic              out_valid_q;

  logic              cmd_q;
  logic [RANK_W-1:0] idx_q;
  logic [N_W-1:0]    c_q;
  logic [I_W-1:0]    i_q;
  logic [ELEM_W-1:0] prev_q;
  cus_status_e       st_q;
  logic [ELEM_W-1:0] cur_q [MAX_PICKS];

  logic [ELEM_W-1:0] elem_q;
  logic [POS_W-1:0]  pos_q;
  logic              last_q;
  cus_status_e       ost_q;

  logic [RANK_W-1:0] binom_tbl [MAX_SET_SIZE][MAX_PICKS];

  logic [N_W-1:0]    n_eff;
  logic [K_W-1:0]    k_eff;
  logic [N_W-1:0]    k_n;
  logic [N_W-1:0]    i_n;
  logic [K_W-1:0]    i_k;
  logic [PIDX_W-1:0] pidx;
  logic [ELEM_W-1:0] cur_rd;
  logic [N_W-1:0]    tbl_a;
  logic [K_W-1:0]    tbl_b;
  logic [RANK_W-1:0] cnt;
  logic              take;
  logic              out_busy;

  for (genvar ga = 0; ga < MAX_SET_SIZE; ga++) begin : g_row
    for (genvar gb = 0; gb < MAX_PICKS; gb++) begin : g_col
      assign binom_tbl[ga][gb] = RANK_W'(binom(ga, gb));
    end
  end

  cus_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cw_o    (cw)
  );

  always_comb begin
    n_eff = (set_size_q > NMax) ? NMax : set_size_q;
    if (pick_count_q == '0) begin
      k_eff = K_W'(1);
    end else if (pick_count_q > KMax) begin
      k_eff = KMax;
    end else begin
      k_eff = pick_count_q;
    end
    k_n    = N_W'(k_eff);
    i_n    = N_W'(i_q);
    i_k    = K_W'(i_q);
    pidx   = i_q[PIDX_W-1:0];
    cur_rd = cur_q[pidx];
    // combinations that start with candidate c at position i
    tbl_a  = n_eff - N_W'(1) - c_q;
    tbl_b  = k_eff - K_W'(1) - i_k;
    cnt    = binom_tbl[tbl_a[AW-1:0]][tbl_b[PIDX_W-1:0]];
    take   = idx_q < cnt;
    out_busy = out_valid_q && !out_o.ready;

    flags.no_input   = !in_i.valid;
    flags.is_adv     = cmd_q;
    flags.kgtn       = k_n > n_eff;
    // candidates ran out while the index still remains
    flags.walk_bad   = !take && ((cnt == '0) || ((c_q + N_W'(1)) >= n_eff));
    flags.walk_more  = i_k != k_eff;
    flags.emit_loop  = out_busy || ((i_k + K_W'(1)) != k_eff);
    flags.not_loaded = !loaded_q;
    flags.i_zero     = i_q == '0;
    flags.cur_at_max = N_W'(cur_rd) >= (n_eff - k_n + i_n);
    flags.i_eq_k     = i_k == k_eff;
    flags.out_busy   = out_busy;
  end

  assign in_i.ready     = cw.act == ACT_LATCH;
  assign out_o.valid    = out_valid_q;
  assign out_o.element  = elem_q;
  assign out_o.position = pos_q;
  assign out_o.is_last  = last_q;
  assign out_o.status   = ost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q   <= SET_SIZE_RST;
      pick_count_q <= PICK_COUNT_RST;
      loaded_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SET_SIZE:   set_size_q   <= cfg_data_i[N_W-1:0];
          REG_PICK_COUNT: pick_count_q <= cfg_data_i[K_W-1:0];
          default: ;
        endcase
        loaded_q <= 1'b0;
      end else if (cw.act == ACT_SET_LOADED) begin
        loaded_q <= 1'b1;
      end
      if ((cw.act == ACT_EMIT || cw.act == ACT_EMIT_ERR) && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cw.act)
      ACT_LATCH: begin
        if (in_i.valid) begin
          cmd_q <= in_i.command;
          idx_q <= in_i.rank_index;
        end
      end
      ACT_UNR_INIT: begin
        c_q <= '0;
        i_q <= '0;
      end
      ACT_WALK: begin
        c_q <= c_q + N_W'(1);
        if (take) begin
          cur_q[pidx] <= ELEM_W'(c_q);
          i_q         <= i_q + I_W'(1);
        end else begin
          idx_q <= idx_q - cnt;
        end
      end
      ACT_CLR_I: i_q <= '0;
      ACT_EMIT: begin
        if (!out_busy) begin
          elem_q <= cur_rd;
          pos_q  <= POS_W'(i_q);
          last_q <= (i_k + K_W'(1)) == k_eff;
          ost_q  <= ST_OK;
          i_q    <= i_q + I_W'(1);
        end
      end
      ACT_ADV_INIT: i_q <= I_W'(k_eff);
      ACT_DEC_I:    i_q <= i_q - I_W'(1);
      ACT_BUMP: begin
        cur_q[pidx] <= cur_rd + ELEM_W'(1);
        prev_q      <= cur_rd + ELEM_W'(1);
        i_q         <= i_q + I_W'(1);
      end
      ACT_FILL: begin
        cur_q[pidx] <= prev_q + ELEM_W'(1);
        prev_q      <= prev_q + ELEM_W'(1);
        i_q         <= i_q + I_W'(1);
      end
      ACT_SET_ST: st_q <= cw.st;
      ACT_EMIT_ERR: begin
        if (!out_busy) begin
          elem_q <= '0;
          pos_q  <= '0;
          last_q <= 1'b1;
          ost_q  <= st_q;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import cus_pkg::*;

  localparam int unsigned N_CAP       = 32;
  localparam int unsigned K_CAP       = 8;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SETTLE      = 100;

  localparam logic CMD_UNRANK  = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [RANK_W-1:0] rank_index;
  } subset_cmd_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic [POS_W-1:0]  position;
    logic              is_last;
    logic [ST_W-1:0]   status;
  } subset_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  cus_in_if  in_if ();
  cus_out_if out_if ();

  combination_unrank_and_step_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the block's registers and stored combination
  logic [N_W-1:0]    set_size_q;
  logic [K_W-1:0]    pick_count_q;
  logic [ELEM_W-1:0] held_subset [K_CAP];
  logic              subset_loaded;

  subset_cmd_t    pending_cmds [$];
  subset_result_t expected_subsets [$];
  subset_cmd_t    next_cmd;
  int unsigned    mismatch_count = 0;
  int unsigned    src_gap;
  int unsigned    sink_gap;
  int unsigned    quiet_cycles = 0;
  bit             idle_enable;
  bit             hold_request;
  bit             hold_done;

  function automatic int unsigned binomial(int unsigned a, int unsigned b);
    longint unsigned c;
    int unsigned     i;
    c = 1;
    if (b > a) return 0;
    for (i = 0; i < b; i++) c = c * (a - i) / (i + 1);
    return 32'(c);
  endfunction

  function automatic int unsigned eff_set_size(logic [N_W-1:0] raw);
    return (raw > N_CAP) ? N_CAP : raw;
  endfunction

  function automatic int unsigned eff_pick_count(logic [K_W-1:0] raw);
    if (raw == 0) return 1;
    return (raw > K_CAP) ? K_CAP : raw;
  endfunction

  function automatic void expect_error(cus_status_e code);
    expected_subsets.push_back('{element: '0, position: '0, is_last: 1'b1, status: code});
  endfunction

  function automatic void expect_subset(int unsigned k);
    int unsigned i;
    for (i = 0; i < k; i++)
      expected_subsets.push_back('{element: held_subset[i], position: POS_W'(i),
                                   is_last: (i + 1 == k), status: ST_OK});
  endfunction

  function automatic void predict_command(logic cmd, logic [RANK_W-1:0] rank);
    int unsigned       n, k, c, next_elem, i, remaining, span;
    int                m;
    bit                found;
    logic [ELEM_W-1:0] walk [K_CAP];
    n = eff_set_size(set_size_q);
    k = eff_pick_count(pick_count_q);
    found = 1'b0;
    if (cmd == CMD_UNRANK) begin
      if (k > n) begin
        expect_error(ST_KGTN);
      end else if (rank >= binomial(n, k)) begin
        expect_error(ST_RANGE);
      end else begin
        remaining = 32'(rank);
        next_elem = 0;
        for (i = 0; i < k; i++) begin
          // skip candidates while the rank lies past every subset that starts with them
          c = next_elem;
          span = binomial(n - 1 - c, k - 1 - i);
          while (remaining >= span && c + 1 < n) begin
            remaining -= span;
            c++;
            span = binomial(n - 1 - c, k - 1 - i);
          end
          walk[i] = ELEM_W'(c);
          next_elem = c + 1;
        end
        for (i = 0; i < k; i++) held_subset[i] = walk[i];
        subset_loaded = 1'b1;
        expect_subset(k);
      end
    end else if (!subset_loaded) begin
      expect_error(ST_EMPTY);
    end else if (k > n) begin
      expect_error(ST_KGTN);
    end else begin
      m = k;
      while (m > 0 && !found) begin
        m--;
        if (held_subset[m] < n - k + m) found = 1'b1;
      end
      if (!found) begin
        expect_error(ST_DONE);
      end else begin
        held_subset[m] = held_subset[m] + 1'b1;
        for (i = m + 1; i < k; i++) held_subset[i] = held_subset[i-1] + 1'b1;
        expect_subset(k);
      end
    end
  endfunction

  function automatic void report_mismatch(string what, subset_result_t want,
                                          subset_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected elem %0d pos %0d last %0b status %0d, %s %0d %0d %0b %0d",
               $time, what, want.element, want.position, want.is_last, want.status,
               "got", got.element, got.position, got.is_last, got.status);
  endfunction

  function automatic void check_result(subset_result_t got);
    subset_result_t want;
    if (expected_subsets.size() == 0) begin
      report_mismatch("unexpected result", '0, got);
      return;
    end
    want = expected_subsets.pop_front();
    if (got.element !== want.element || got.position !== want.position ||
        got.is_last !== want.is_last || got.status !== want.status)
      report_mismatch("result mismatch", want, got);
  endfunction

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.command    <= CMD_UNRANK;
      in_if.rank_index <= '0;
      src_gap          <= 0;
      set_size_q       = SET_SIZE_RST;
      pick_count_q     = PICK_COUNT_RST;
      subset_loaded    = 1'b0;
    end else begin
      // shadow register writes; any write drops the stored subset
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SET_SIZE) set_size_q = cfg_data_i[N_W-1:0];
        else pick_count_q = cfg_data_i[K_W-1:0];
        subset_loaded = 1'b0;
      end
      if (in_if.valid && in_if.ready) predict_command(in_if.command, in_if.rank_index);
      if (!in_if.valid || in_if.ready) begin
        if (src_gap != 0) begin
          src_gap     <= src_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 11) == 0) begin
          src_gap     <= $urandom_range(0, 13);
          in_if.valid <= 1'b0;
        end else begin
          next_cmd          = pending_cmds.pop_front();
          in_if.valid      <= 1'b1;
          in_if.command    <= next_cmd.command;
          in_if.rank_index <= next_cmd.rank_index;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_gap     <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready)
        check_result('{out_if.element, out_if.position, out_if.is_last, out_if.status});
      if (hold_request && !hold_done) begin
        // long hold-off so the block backs up and stalls its input
        hold_done    <= 1'b1;
        sink_gap     <= HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap     <= sink_gap - 1;
        out_if.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        sink_gap     <= $urandom_range(0, 13);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_cmd(logic cmd, logic [RANK_W-1:0] rank);
    pending_cmds.push_back('{command: cmd, rank_index: rank});
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_if.valid || expected_subsets.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly an unrank followed by a run of advances, with some noise in between
  task automatic fill_phase(int unsigned count);
    int unsigned n, k, total, made, run, idx;
    n = eff_set_size(set_size_q);
    k = eff_pick_count(pick_count_q);
    total = (k > n) ? 0 : binomial(n, k);
    made = 0;
    while (made < count) begin
      if (total != 0 && $urandom_range(0, 9) < 8) begin
        // bias toward the tail so advances run into exhaustion
        if ($urandom_range(0, 3) == 0)
          idx = total - 1 - $urandom_range(0, (total > 4) ? 3 : total - 1);
        else
          idx = $urandom_range(0, total - 1);
        queue_cmd(CMD_UNRANK, RANK_W'(idx));
        run = $urandom_range(0, 6);
        repeat (run) queue_cmd(CMD_ADVANCE, RANK_W'($urandom()));
        made += 1 + run;
      end else begin
        queue_cmd(1'($urandom_range(0, 1)), RANK_W'($urandom()));
        made++;
      end
    end
  endtask

  task automatic run_phase(logic [CFG_W-1:0] n_data, logic [CFG_W-1:0] k_data,
                           int unsigned count);
    wait_drained();
    write_reg(REG_SET_SIZE, n_data);
    write_reg(REG_PICK_COUNT, k_data);
    @(negedge clk_i);
    fill_phase(count);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_SET_SIZE;
    cfg_data_i       = '0;
    idle_enable      = 1'b1;
    hold_request     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration, 8 of 16
    @(negedge clk_i);
    queue_cmd(CMD_ADVANCE, '0);
    queue_cmd(CMD_UNRANK, '0);
    queue_cmd(CMD_ADVANCE, '1);
    queue_cmd(CMD_UNRANK, RANK_W'(binomial(16, 8) - 1));
    queue_cmd(CMD_ADVANCE, '0);
    queue_cmd(CMD_ADVANCE, '0);
    queue_cmd(CMD_UNRANK, RANK_W'(binomial(16, 8)));
    queue_cmd(CMD_UNRANK, '1);
    queue_cmd(CMD_ADVANCE, '0);

    // both registers above their caps
    wait_drained();
    write_reg(REG_SET_SIZE, 6'd63);
    write_reg(REG_PICK_COUNT, 6'd15);
    @(negedge clk_i);
    queue_cmd(CMD_ADVANCE, '0);
    queue_cmd(CMD_UNRANK, '0);
    queue_cmd(CMD_UNRANK, RANK_W'(binomial(N_CAP, K_CAP) - 1));
    queue_cmd(CMD_ADVANCE, '0);
    queue_cmd(CMD_UNRANK, RANK_W'(binomial(N_CAP, K_CAP)));

    // empty set: every command fails, advance reports nothing loaded first
    wait_drained();
    write_reg(REG_SET_SIZE, 6'd0);
    @(negedge clk_i);
    queue_cmd(CMD_ADVANCE, '0);
    queue_cmd(CMD_UNRANK, '0);

    // k of zero behaves as one
    wait_drained();
    write_reg(REG_PICK_COUNT, 6'd0);
    write_reg(REG_SET_SIZE, 6'd1);
    @(negedge clk_i);
    queue_cmd(CMD_UNRANK, '0);
    queue_cmd(CMD_ADVANCE, '0);
    queue_cmd(CMD_UNRANK, 24'd1);

    run_phase(6'd1, 6'd1, 30);
    run_phase(6'd2, 6'd48, 30);
    run_phase(6'd32, 6'd8, 50);
    hold_request = 1'b1;
    run_phase(6'd63, 6'd31, 40);
    run_phase(6'd0, 6'd5, 10);
    run_phase(6'd8, 6'd8, 20);
    repeat (4) run_phase(CFG_W'($urandom_range(1, 63)), CFG_W'($urandom_range(0, 63)), 40);
    idle_enable = 1'b0;
    repeat (2) run_phase(CFG_W'($urandom_range(1, 63)), CFG_W'($urandom_range(0, 63)), 40);

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && expected_subsets.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
